/* sv/appletalk_frame_field_parser_top_macros.svh */
// Assertion macros shared by the frame field parser RTL.
// Used by appletalk_frame_field_parser_top.sv; expects clk and arst_n in scope.
`ifndef APPLETALK_FRAME_FIELD_PARSER_TOP_MACROS_SVH
`define APPLETALK_FRAME_FIELD_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/afp_pkg.sv */
// Package for the frame field parser: byte offsets, codes and walker types.
// No dependencies; imported by appletalk_frame_field_parser_top.
`default_nettype none

package afp_pkg;

	localparam int MAX_FRAME_BYTES = 1024;
	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

	// Byte offsets within the link frame.
	localparam int TYPE_AT = 2;
	localparam int MIN_DDP_BYTES = 4;
	localparam int SHORT_SOCKET_AT = 5;
	localparam int SHORT_KIND_AT = 7;
	localparam int SHORT_PAY_AT = 8;
	localparam int LONG_NODE_AT = 11;
	localparam int LONG_SOCKET_AT = 13;
	localparam int LONG_KIND_AT = 15;
	localparam int LONG_PAY_AT = 16;

	// Header classes.
	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_SHORT = 2'd1;
	localparam logic [1:0] CLS_LONG = 2'd2;

	// Datagram protocol types.
	localparam logic [7:0] KIND_NBP = 8'd2;
	localparam logic [7:0] KIND_ATP = 8'd3;

	// Tuple walker positions: 0..4 fixed fields, 5/7/9 string lengths,
	// 6/8/10 string bodies, done once the selected tuple is complete.
	localparam logic [3:0] POS_LAST_FIXED = 4'd4;
	localparam logic [3:0] POS_LEN_A = 4'd5;
	localparam logic [3:0] POS_LEN_B = 4'd7;
	localparam logic [3:0] POS_LEN_C = 4'd9;
	localparam logic [3:0] POS_NET_LO = 4'd2;
	localparam logic [3:0] WALK_DONE = 4'd11;

	typedef struct packed {
		logic [3:0] tn;
		logic [3:0] pos;
	} walk_t;

	typedef struct packed {
		logic [1:0]  ddp_class;
		logic [7:0]  ddp_kind;
		logic [7:0]  dest_node;
		logic [7:0]  dest_socket;
		logic [3:0]  function_code;
		logic [3:0]  nbp_count;
		logic [7:0]  nbp_ident;
		logic        tuple_ok;
		logic [15:0] tuple_network;
		logic [7:0]  tuple_node;
		logic [7:0]  tuple_socket;
		logic [7:0]  tuple_enumerator;
	} afp_result_t;

endpackage

`default_nettype wire

/* sv/appletalk_frame_field_parser_top.sv */
// Top level of the link frame field parser: input stage, frame state, summary register.
// Depends on afp_pkg and appletalk_frame_field_parser_top_macros.svh.
//
//   channel | signals                                   | beat
//   --------+-------------------------------------------+------------------------------
//   in      | in_valid, in_stall, data_byte, frame_last | one frame byte
//   out     | out_valid, out_stall, twelve summary ports | one summary per frame
//   cfg     | cfg_wr_en, cfg_wr_data                    | write of tuple_select
//
// A byte is accepted into the input register and folded into the frame state when
// the input register moves on. When it is a last byte, its summary is loaded into
// the summary register at that same edge and out_valid rises with it; a new byte can
// be taken every cycle unless a last byte is held for a waiting summary. Reset clears
// all frame state and both valid flags; there is no clearing pass. A stalled summary
// holds back only the next frame's last byte; bytes ahead of it keep flowing into the frame state.
`default_nettype none

module appletalk_frame_field_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [3:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       ddp_class,
	output logic [7:0]       ddp_kind,
	output logic [7:0]       dest_node,
	output logic [7:0]       dest_socket,
	output logic [3:0]       function_code,
	output logic [3:0]       nbp_count,
	output logic [7:0]       nbp_ident,
	output logic             tuple_ok,
	output logic [15:0]      tuple_network,
	output logic [7:0]       tuple_node,
	output logic [7:0]       tuple_socket,
	output logic [7:0]       tuple_enumerator
);
	import afp_pkg::*;

	`include "appletalk_frame_field_parser_top_macros.svh"

	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_BYTES);

	// Configuration register.
	logic [3:0] tuple_select_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state.
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       hk_q;
	logic [7:0]       kind_q, node_q, socket_q, p0_q, p1_q;
	logic [3:0]       tn_q, pos_q;
	logic [7:0]       left_q;
	logic [39:0]      cap_q;

	// Next frame state.
	logic [IDX_W-1:0] idx_n;
	logic [1:0]       hk_n;
	logic [7:0]       kind_n, node_n, socket_n, p0_n, p1_n;
	logic [3:0]       tn_n, pos_n;
	logic [7:0]       left_n;
	logic [39:0]      cap_n;

	logic [IDX_W-1:0] pay;
	logic             take;
	logic             mine;
	logic             adv;
	walk_t            walk_es;
	afp_result_t      res, res_q;
	logic             out_valid_q;

	// Step past a finished string: next length byte, walk done, or next tuple.
	function automatic walk_t end_string(input logic [3:0] p, input logic [3:0] tn,
			input logic [3:0] sel);
		walk_t w;
		w.tn = tn;
		if (p < POS_LEN_C) begin
			w.pos = p + 4'd1;
		end else if (tn == sel) begin
			w.pos = WALK_DONE;
		end else begin
			w.tn = tn + 4'd1;
			w.pos = 4'd0;
		end
		return w;
	endfunction

	// The input register moves on unless it holds a last byte and the summary
	// register is still waiting to be taken.
	assign adv = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuple_select_q <= '0;
		end else if (cfg_wr_en) begin
			tuple_select_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= frame_last;
		end
	end

	// Field update for one byte. Captures look at the byte index before it
	// advances; the class taken at byte 2 decides every later offset.
	always_comb begin
		idx_n = idx_q;
		hk_n = hk_q;
		kind_n = kind_q;
		node_n = node_q;
		socket_n = socket_q;
		p0_n = p0_q;
		p1_n = p1_q;
		tn_n = tn_q;
		pos_n = pos_q;
		left_n = left_q;
		cap_n = cap_q;
		pay = '0;
		walk_es = '0;
		take = idx_q < IDX_MAX;
		mine = tn_q == tuple_select_q;

		if (take) begin
			idx_n = idx_q + 1'b1;
			if (idx_q == '0) begin
				node_n = byte_s1;
			end
			if (idx_q == IDX_W'(TYPE_AT)) begin
				if (byte_s1 == 8'd1) begin
					hk_n = CLS_SHORT;
				end else if (byte_s1 == 8'd2) begin
					hk_n = CLS_LONG;
					node_n = 8'd0;
				end else begin
					hk_n = CLS_NONE;
				end
			end

			if (hk_n == CLS_SHORT) begin
				pay = IDX_W'(SHORT_PAY_AT);
				if (idx_q == IDX_W'(SHORT_SOCKET_AT)) socket_n = byte_s1;
				if (idx_q == IDX_W'(SHORT_KIND_AT)) kind_n = byte_s1;
			end else if (hk_n == CLS_LONG) begin
				pay = IDX_W'(LONG_PAY_AT);
				if (idx_q == IDX_W'(LONG_NODE_AT)) node_n = byte_s1;
				if (idx_q == IDX_W'(LONG_SOCKET_AT)) socket_n = byte_s1;
				if (idx_q == IDX_W'(LONG_KIND_AT)) kind_n = byte_s1;
			end

			if (pay != '0) begin
				if (idx_q == pay) p0_n = byte_s1;
				if (idx_q == pay + 1'b1) p1_n = byte_s1;
				if (idx_q >= pay + 2'd2 && pos_q < WALK_DONE) begin
					if (pos_q <= POS_LAST_FIXED) begin
						if (mine) begin
							case (pos_q[2:0])
								3'd0: cap_n[39:32] = cap_q[39:32] | byte_s1;
								3'd1: cap_n[31:24] = cap_q[31:24] | byte_s1;
								3'd2: cap_n[23:16] = cap_q[23:16] | byte_s1;
								3'd3: cap_n[15:8] = cap_q[15:8] | byte_s1;
								3'd4: cap_n[7:0] = cap_q[7:0] | byte_s1;
								default: cap_n = cap_q;
							endcase
						end
						pos_n = pos_q + 4'd1;
					end else if (pos_q == POS_LEN_A || pos_q == POS_LEN_B ||
							pos_q == POS_LEN_C) begin
						if (byte_s1 == 8'd0) begin
							walk_es = end_string(pos_q + 4'd1, tn_q, tuple_select_q);
							tn_n = walk_es.tn;
							pos_n = walk_es.pos;
						end else begin
							left_n = byte_s1;
							pos_n = pos_q + 4'd1;
						end
					end else begin
						left_n = left_q - 8'd1;
						if (left_n == 8'd0) begin
							walk_es = end_string(pos_q, tn_q, tuple_select_q);
							tn_n = walk_es.tn;
							pos_n = walk_es.pos;
						end
					end
				end
			end
		end
	end

	// Summary from the state as it stands after the last byte.
	always_comb begin
		res = '0;
		if (idx_n >= IDX_W'(MIN_DDP_BYTES) && hk_n != CLS_NONE) begin
			res.ddp_class = hk_n;
			res.ddp_kind = kind_n;
			res.dest_node = node_n;
			res.dest_socket = socket_n;
			if (kind_n == KIND_NBP) begin
				res.function_code = p0_n[7:4];
				res.nbp_count = p0_n[3:0];
				res.nbp_ident = p1_n;
				if (tn_n == tuple_select_q || pos_n == WALK_DONE) begin
					// A network number whose low byte never arrived reads as zero.
					if (pos_n >= POS_NET_LO) res.tuple_network = cap_n[39:24];
					res.tuple_node = cap_n[23:16];
					res.tuple_socket = cap_n[15:8];
					res.tuple_enumerator = cap_n[7:0];
				end
				res.tuple_ok = pos_n == WALK_DONE;
			end else if (kind_n == KIND_ATP) begin
				res.function_code = {2'b00, p0_n[7:6]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hk_q <= CLS_NONE;
			kind_q <= '0;
			node_q <= '0;
			socket_q <= '0;
			p0_q <= '0;
			p1_q <= '0;
			tn_q <= '0;
			pos_q <= '0;
			left_q <= '0;
			cap_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				idx_q <= '0;
				hk_q <= CLS_NONE;
				kind_q <= '0;
				node_q <= '0;
				socket_q <= '0;
				p0_q <= '0;
				p1_q <= '0;
				tn_q <= '0;
				pos_q <= '0;
				left_q <= '0;
				cap_q <= '0;
			end else begin
				idx_q <= idx_n;
				hk_q <= hk_n;
				kind_q <= kind_n;
				node_q <= node_n;
				socket_q <= socket_n;
				p0_q <= p0_n;
				p1_q <= p1_n;
				tn_q <= tn_n;
				pos_q <= pos_n;
				left_q <= left_n;
				cap_q <= cap_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign ddp_class = res_q.ddp_class;
	assign ddp_kind = res_q.ddp_kind;
	assign dest_node = res_q.dest_node;
	assign dest_socket = res_q.dest_socket;
	assign function_code = res_q.function_code;
	assign nbp_count = res_q.nbp_count;
	assign nbp_ident = res_q.nbp_ident;
	assign tuple_ok = res_q.tuple_ok;
	assign tuple_network = res_q.tuple_network;
	assign tuple_node = res_q.tuple_node;
	assign tuple_socket = res_q.tuple_socket;
	assign tuple_enumerator = res_q.tuple_enumerator;

	`AFP_ASSERT_NXT(a_last_gives_summary, adv && last_s1, out_valid_q && idx_q == '0 && pos_q == '0, "last beat did not load a summary and clear the frame")
	`AFP_ASSERT_NOW(a_ok_needs_nbp, out_valid_q && res_q.tuple_ok, res_q.ddp_kind == KIND_NBP && res_q.ddp_class != CLS_NONE, "tuple_ok set outside a name binding datagram")
	`AFP_ASSERT_NOW(a_walk_pos_range, 1'b1, pos_q <= WALK_DONE, "tuple walker position out of range")
	`AFP_ASSERT_NOW(a_index_saturates, 1'b1, idx_q <= IDX_MAX, "byte index passed the frame limit")
	`AFP_ASSERT_NOW(a_stall_only_on_last, in_stall, valid_s1 && last_s1 && out_valid_q, "input stalled without a waiting summary")

endmodule

`default_nettype wire

/* tb/sv/appletalk_frame_field_parser_top_tb.sv */
// Self-checking testbench for the AppleTalk link frame field parser top level.
// It streams frame bytes, writes tuple_select between phases and predicts every
// frame summary in-line; it depends on afp_pkg and appletalk_frame_field_parser_top.
module appletalk_frame_field_parser_top_tb;
	import afp_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int TIMEOUT_CYCLES = 500_000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 90;

	// Receiver behavior and sender gap behavior, chosen per phase.
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_e;
	typedef enum logic [1:0] {GAPS_NONE, GAPS_SHORT, GAPS_LONG} gap_mode_e;

	// One input beat: a frame byte and its last-byte flag.
	typedef struct {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [3:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        frame_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  ddp_class;
	logic [7:0]  ddp_kind;
	logic [7:0]  dest_node;
	logic [7:0]  dest_socket;
	logic [3:0]  function_code;
	logic [3:0]  nbp_count;
	logic [7:0]  nbp_ident;
	logic        tuple_ok;
	logic [15:0] tuple_network;
	logic [7:0]  tuple_node;
	logic [7:0]  tuple_socket;
	logic [7:0]  tuple_enumerator;

	// Beats waiting for the driver, and the summaries the predictor has produced
	// for frames whose last byte has already been accepted.
	frame_beat_t  frame_beats_pending[$];
	afp_result_t  summaries_due[$];
	logic [7:0]   frame_bytes[$];

	// Knobs that the sequencer sets and the driver and receiver read.
	stall_mode_e stall_mode = STALL_NONE;
	gap_mode_e   gap_mode = GAPS_NONE;
	logic        sender_hold = 1'b0;
	int          hold_requests = 0;
	int          mismatches = 0;

	// Predictor copy of the parser state, cleared after every summary.
	logic [3:0]  sel_model = '0;
	int          seen_bytes = 0;
	logic [1:0]  hdr_class = CLS_NONE;
	logic [7:0]  cap_kind = '0;
	logic [7:0]  cap_node = '0;
	logic [7:0]  cap_socket = '0;
	logic [7:0]  cap_pay0 = '0;
	logic [7:0]  cap_pay1 = '0;
	logic [3:0]  walk_tuple_no = '0;
	logic [3:0]  walk_pos = '0;
	logic [7:0]  str_left = '0;
	logic [39:0] tuple_bits = '0;

	appletalk_frame_field_parser_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.frame_last       (frame_last),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.ddp_class        (ddp_class),
		.ddp_kind         (ddp_kind),
		.dest_node        (dest_node),
		.dest_socket      (dest_socket),
		.function_code    (function_code),
		.nbp_count        (nbp_count),
		.nbp_ident        (nbp_ident),
		.tuple_ok         (tuple_ok),
		.tuple_network    (tuple_network),
		.tuple_node       (tuple_node),
		.tuple_socket     (tuple_socket),
		.tuple_enumerator (tuple_enumerator)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// A string of the tuple has ended. Step to the next length byte, or close the
	// tuple: the walk stops for good once the selected tuple is complete.
	function automatic void close_string();
		if (walk_pos < POS_LEN_C) begin
			walk_pos = walk_pos + 4'd1;
		end else if (walk_tuple_no == sel_model) begin
			walk_pos = WALK_DONE;
		end else begin
			walk_tuple_no = walk_tuple_no + 4'd1;
			walk_pos = '0;
		end
	endfunction

	// One payload byte from the third on: fixed fields first, then three strings,
	// each a length byte followed by that many bytes.
	function automatic void walk_byte(input logic [7:0] b);
		int shift;
		shift = 8 * (int'(POS_LAST_FIXED) - int'(walk_pos));
		if (walk_pos >= WALK_DONE) begin
			return;
		end
		if (walk_pos <= POS_LAST_FIXED) begin
			if (walk_tuple_no == sel_model) begin
				tuple_bits[shift +: 8] = b;
			end
			walk_pos = walk_pos + 4'd1;
		end else if (walk_pos == POS_LEN_A || walk_pos == POS_LEN_B || walk_pos == POS_LEN_C) begin
			walk_pos = walk_pos + 4'd1;
			if (b == 8'd0) begin
				close_string();
			end else begin
				str_left = b;
			end
		end else begin
			str_left = str_left - 8'd1;
			if (str_left == 8'd0) begin
				close_string();
			end
		end
	endfunction

	// Folds one accepted beat into the predicted frame state. On the last byte it
	// builds the summary, clears the state and returns 1.
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output afp_result_t res);
		int pay_at;
		res = '0;
		// Bytes past the size limit are dropped, but their last flag still counts.
		if (seen_bytes < MAX_FRAME_BYTES) begin
			if (seen_bytes == 0) begin
				cap_node = b;
			end
			if (seen_bytes == TYPE_AT) begin
				hdr_class = (b == 8'd1) ? CLS_SHORT : (b == 8'd2) ? CLS_LONG : CLS_NONE;
				if (hdr_class == CLS_LONG) begin
					cap_node = '0;
				end
			end
			pay_at = 0;
			if (hdr_class == CLS_SHORT) begin
				pay_at = SHORT_PAY_AT;
				if (seen_bytes == SHORT_SOCKET_AT) cap_socket = b;
				if (seen_bytes == SHORT_KIND_AT) cap_kind = b;
			end else if (hdr_class == CLS_LONG) begin
				pay_at = LONG_PAY_AT;
				if (seen_bytes == LONG_NODE_AT) cap_node = b;
				if (seen_bytes == LONG_SOCKET_AT) cap_socket = b;
				if (seen_bytes == LONG_KIND_AT) cap_kind = b;
			end
			if (pay_at != 0) begin
				if (seen_bytes == pay_at) cap_pay0 = b;
				if (seen_bytes == pay_at + 1) cap_pay1 = b;
				if (seen_bytes >= pay_at + 2) walk_byte(b);
			end
			seen_bytes++;
		end
		if (!last) begin
			return 1'b0;
		end
		// A frame too short to hold the class byte and one more is never a datagram.
		if (seen_bytes >= MIN_DDP_BYTES && hdr_class != CLS_NONE) begin
			res.ddp_class = hdr_class;
			res.ddp_kind = cap_kind;
			res.dest_node = cap_node;
			res.dest_socket = cap_socket;
			if (cap_kind == KIND_NBP) begin
				res.function_code = cap_pay0[7:4];
				res.nbp_count = cap_pay0[3:0];
				res.nbp_ident = cap_pay1;
				if (walk_tuple_no == sel_model || walk_pos == WALK_DONE) begin
					// The network number needs both of its bytes.
					if (walk_pos >= POS_NET_LO) begin
						res.tuple_network = tuple_bits[39:24];
					end
					res.tuple_node = tuple_bits[23:16];
					res.tuple_socket = tuple_bits[15:8];
					res.tuple_enumerator = tuple_bits[7:0];
				end
				res.tuple_ok = (walk_pos == WALK_DONE);
			end else if (cap_kind == KIND_ATP) begin
				res.function_code = {2'b00, cap_pay0[7:6]};
			end
		end
		seen_bytes = 0;
		hdr_class = CLS_NONE;
		cap_kind = '0;
		cap_node = '0;
		cap_socket = '0;
		cap_pay0 = '0;
		cap_pay1 = '0;
		walk_tuple_no = '0;
		walk_pos = '0;
		str_left = '0;
		tuple_bits = '0;
		return 1'b1;
	endfunction

	// Driver. Each accepted beat goes through the predictor at the edge that takes
	// it. A new beat is offered only once the current one is gone, so a stalled
	// payload stays put. Bursts of random length alternate with random gaps set by the gap mode.
	always @(posedge clk) begin
		afp_result_t res;
		frame_beat_t beat;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (parse_byte(data_byte, frame_last, res)) begin
					summaries_due.push_back(res);
				end
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || sender_hold || frame_beats_pending.size() == 0) begin
					// Idle cycles carry junk on the payload, which the block must ignore.
					in_valid <= 1'b0;
					data_byte <= 8'($urandom);
					frame_last <= 1'($urandom);
					if (gap_left > 0) begin
						gap_left--;
					end
				end else begin
					beat = frame_beats_pending.pop_front();
					in_valid <= 1'b1;
					data_byte <= beat.data;
					frame_last <= beat.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						case (gap_mode)
							GAPS_SHORT: gap_left = $urandom_range(0, 3);
							GAPS_LONG: gap_left = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(4, 12);
							default: gap_left = 0;
						endcase
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Receiver. A long hold, once requested, is counted out here; otherwise the
	// stall follows the mode of the phase.
	always @(posedge clk) begin
		int hold_taken;
		int hold_left;
		logic [7:0] stall_pattern;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_taken = 0;
			hold_left = 0;
			stall_pattern = 8'b1110_0100;
		end else if (hold_taken != hold_requests) begin
			hold_taken = hold_requests;
			hold_left = LONG_HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
			case (stall_mode)
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PATTERN: out_stall <= stall_pattern[0];
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	// Monitor. Every summary beat is matched against the oldest prediction.
	always @(posedge clk) begin
		afp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (summaries_due.size() == 0) begin
				report_mismatch("summary beat with no frame outstanding");
			end else begin
				want = summaries_due.pop_front();
				check_field("ddp_class", ddp_class, want.ddp_class);
				check_field("ddp_kind", ddp_kind, want.ddp_kind);
				check_field("dest_node", dest_node, want.dest_node);
				check_field("dest_socket", dest_socket, want.dest_socket);
				check_field("function_code", function_code, want.function_code);
				check_field("nbp_count", nbp_count, want.nbp_count);
				check_field("nbp_ident", nbp_ident, want.nbp_ident);
				check_field("tuple_ok", tuple_ok, want.tuple_ok);
				check_field("tuple_network", tuple_network, want.tuple_network);
				check_field("tuple_node", tuple_node, want.tuple_node);
				check_field("tuple_socket", tuple_socket, want.tuple_socket);
				check_field("tuple_enumerator", tuple_enumerator, want.tuple_enumerator);
			end
		end
	end

	function automatic logic [7:0] pick_byte(input int fill);
		return (fill < 0) ? 8'($urandom) : 8'(fill);
	endfunction

	// Builds a frame in frame_bytes: a short header when the class byte is 1, a
	// long one when it is 2, and a short-sized header otherwise. Name binding
	// frames get the count/id bytes and ntup tuples with strings up to maxstr
	// long; other kinds get a few payload bytes. A fill of -1 means random bytes.
	task automatic make_frame(input logic [7:0] hb, input logic [7:0] kind, input int ntup,
			input int maxstr, input int fill);
		int hdr_len;
		int n;
		frame_bytes.delete();
		hdr_len = (hb == 8'd2) ? LONG_PAY_AT : SHORT_PAY_AT;
		repeat (hdr_len) frame_bytes.push_back(pick_byte(fill));
		frame_bytes[TYPE_AT] = hb;
		frame_bytes[(hb == 8'd2) ? LONG_KIND_AT : SHORT_KIND_AT] = kind;
		if (kind == KIND_NBP) begin
			repeat (2) frame_bytes.push_back(pick_byte(fill));
			repeat (ntup) begin
				repeat (5) frame_bytes.push_back(pick_byte(fill));
				repeat (3) begin
					n = $urandom_range(0, maxstr);
					frame_bytes.push_back(8'(n));
					repeat (n) frame_bytes.push_back(pick_byte(fill));
				end
			end
		end else begin
			repeat ($urandom_range(1, 6)) frame_bytes.push_back(pick_byte(fill));
		end
	endtask

	// Queues the first cut bytes of frame_bytes (all of them when cut is 0) as
	// beats, the final one flagged, and returns how many were queued.
	function automatic int send_frame(input int cut);
		int n;
		n = (cut == 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
		for (int i = 0; i < n; i++) begin
			frame_beats_pending.push_back('{frame_bytes[i], i == n - 1});
		end
		return n;
	endfunction

	// Waits until every beat is accepted and every predicted summary has come
	// back, then waits on for anything still in the pipe.
	task automatic wait_idle();
		@(negedge clk);
		while (frame_beats_pending.size() != 0 || in_valid || summaries_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Register write; only called with the block idle.
	task automatic set_tuple_select(input logic [3:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		sel_model = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 4'($urandom);
		@(negedge clk);
	endtask

	// Random frames until about budget bytes are queued. Over half are name binding
	// frames, most deep enough to reach the selected tuple; the rest are other kinds,
	// non-datagrams and noise, and any frame may be cut off at a random byte.
	task automatic random_frames(input int budget);
		int sent;
		int r;
		int ntup;
		int maxstr;
		logic [7:0] hb;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			hb = ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd2;
			if (r < 55) begin
				if ($urandom_range(0, 9) < 6) begin
					ntup = $urandom_range(int'(sel_model) + 1, int'(sel_model) + 2);
				end else begin
					ntup = $urandom_range(0, int'(sel_model) + 2);
				end
				maxstr = ($urandom_range(0, 9) == 0) ? 40 : (sel_model > 4'd7) ? 1 : 3;
				make_frame(hb, KIND_NBP, ntup, maxstr, -1);
			end else if (r < 68) begin
				make_frame(hb, KIND_ATP, 0, 0, -1);
			end else if (r < 78) begin
				make_frame(hb, 8'($urandom), 0, 0, -1);
			end else if (r < 88) begin
				hb = 8'($urandom);
				if (hb == 8'd1 || hb == 8'd2) begin
					hb = 8'd0;
				end
				make_frame(hb, 8'($urandom), 0, 0, -1);
			end else begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
			end
			if ($urandom_range(0, 4) == 0) begin
				sent += send_frame($urandom_range(1, frame_bytes.size()));
			end else begin
				sent += send_frame(0);
			end
		end
	endtask

	// Directed frames with tuple_select at its reset value of zero.
	task automatic directed_frames();
		// Short header name binding frame, sent whole and cut at the interesting
		// points: one byte, three bytes (too short), four bytes, before and after
		// the socket byte, with only the high network byte, and mid-tuple.
		make_frame(8'd1, KIND_NBP, 1, 2, -1);
		void'(send_frame(1));
		void'(send_frame(3));
		void'(send_frame(4));
		void'(send_frame(SHORT_SOCKET_AT));
		void'(send_frame(SHORT_SOCKET_AT + 1));
		void'(send_frame(SHORT_PAY_AT + 3));
		void'(send_frame(SHORT_PAY_AT + 4));
		void'(send_frame(frame_bytes.size() - 1));
		void'(send_frame(0));
		// Name binding frames: long header random and all-zero, short header all-ones, and no tuples.
		make_frame(8'd2, KIND_NBP, 3, 2, -1);
		void'(send_frame(0));
		make_frame(8'd2, KIND_NBP, 2, 0, 8'h00);
		void'(send_frame(0));
		make_frame(8'd1, KIND_NBP, 2, 0, 8'hFF);
		void'(send_frame(0));
		make_frame(8'd2, KIND_NBP, 0, 0, -1);
		void'(send_frame(0));
		// Transaction frames: both function bits set, one set, and payload missing.
		make_frame(8'd1, KIND_ATP, 0, 0, -1);
		frame_bytes[SHORT_PAY_AT] = 8'hFF;
		void'(send_frame(0));
		frame_bytes[SHORT_PAY_AT] = 8'h40;
		void'(send_frame(0));
		void'(send_frame(SHORT_PAY_AT));
		make_frame(8'd2, KIND_ATP, 0, 0, 8'hFF);
		frame_bytes[LONG_PAY_AT] = 8'h80;
		void'(send_frame(0));
		// Other protocol types, and frames that are no datagram at all.
		make_frame(8'd2, 8'hFF, 0, 0, -1);
		void'(send_frame(0));
		make_frame(8'd1, 8'h00, 0, 0, -1);
		void'(send_frame(0));
		make_frame(8'd0, KIND_NBP, 0, 0, -1);
		void'(send_frame(0));
		make_frame(8'd3, KIND_NBP, 0, 0, -1);
		void'(send_frame(0));
		make_frame(8'hFF, KIND_ATP, 0, 0, 8'hFF);
		void'(send_frame(0));
	endtask

	initial begin
		logic [3:0] sel_plan[6];
		sel_plan = '{4'd15, 4'd0, 4'd1, 4'($urandom), 4'd7, 4'($urandom)};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		directed_frames();
		wait_idle();

		// Random phases, each with its own register value and its own mix of
		// sender gaps and receiver stalls.
		for (int p = 0; p < 6; p++) begin
			set_tuple_select(sel_plan[p]);
			gap_mode <= gap_mode_e'(p % 3);
			stall_mode <= stall_mode_e'(p % 4);
			if (p == 4) begin
				// Mid-stream the sender holds off until every summary so far has
				// been taken, then resumes.
				random_frames(PHASE_BYTES / 2);
				while (frame_beats_pending.size() > 20) @(negedge clk);
				sender_hold <= 1'b1;
				@(negedge clk);
				while (in_valid || summaries_due.size() != 0) @(negedge clk);
				repeat (20) @(negedge clk);
				sender_hold <= 1'b0;
				random_frames(PHASE_BYTES / 2);
			end else begin
				random_frames(PHASE_BYTES);
			end
			wait_idle();
		end

		// Back pressure: the receiver holds off for a long stretch while short
		// frames stream in without gaps, so the block has to stall its input.
		gap_mode <= GAPS_NONE;
		stall_mode <= STALL_NONE;
		repeat (24) begin
			if ($urandom_range(0, 1) == 0) begin
				make_frame(8'd1, KIND_ATP, 0, 0, -1);
			end else begin
				make_frame(8'd0, 8'($urandom), 0, 0, -1);
			end
			void'(send_frame($urandom_range(4, 10)));
		end
		hold_requests <= hold_requests + 1;
		wait_idle();

		// One more name binding frame with a fresh register value and light stalls.
		set_tuple_select(4'd2);
		gap_mode <= GAPS_SHORT;
		stall_mode <= STALL_LIGHT;
		make_frame(8'd1, KIND_NBP, 4, 2, -1);
		void'(send_frame(0));
		wait_idle();

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: a hung handshake or a lost summary ends the run here.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
